// ===== rtl/smbus_master_transaction_engine_core_defines.svh =====
// assertion macros shared by the smbus master transaction engine rtl
// no dependencies; assertions drop out when SYNTHESIS is defined
`ifndef SMBUS_MASTER_TRANSACTION_ENGINE_CORE_DEFINES_SVH
`define SMBUS_MASTER_TRANSACTION_ENGINE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SMTE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("smte assertion failed");
`define SMTE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   `SMTE_ASSERT(lbl, clk, rst, (ante) |-> (cons))
`else
`define SMTE_ASSERT(lbl, clk, rst, prop)
`define SMTE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/smte_pkg.sv =====
// types, codes and micro-op tables of the smbus master transaction engine
// no dependencies
package smte_pkg;

   typedef enum logic [2:0] {
      PH_IDLE, PH_START, PH_RESTART, PH_STOP, PH_WBYTE, PH_RBYTE, PH_PULSE, PH_TAIL
   } phase_type;

   typedef enum logic [3:0] {
      MO_END, MO_Q, MO_WAIT, MO_SDA_REL, MO_SDA_LOW, MO_SDA_BIT, MO_SCL_LOW,
      MO_SCL_REL, MO_SAMPLE
   } micro_type;

   localparam logic [2:0] OP_PING     = 3'd0;
   localparam logic [2:0] OP_WR_BYTE  = 3'd1;
   localparam logic [2:0] OP_WR_WORD  = 3'd2;
   localparam logic [2:0] OP_RD_BYTE  = 3'd3;
   localparam logic [2:0] OP_RD_WORD  = 3'd4;
   localparam logic [2:0] OP_RD_BLOCK = 3'd5;
   localparam logic [2:0] OP_RECOVER  = 3'd6;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NAK     = 2'd1;
   localparam logic [1:0] ST_TIMEOUT = 2'd2;
   localparam logic [1:0] ST_TRUNC   = 2'd3;

   localparam logic [2:0] SEQ_CMD    = 3'd2;
   localparam logic [2:0] SEQ_ADDR   = 3'd1;
   localparam logic [2:0] SEQ_DATA_L = 3'd3;
   localparam logic [2:0] SEQ_DATA_H = 3'd4;
   localparam logic [2:0] SEQ_RD_1ST = 3'd5;
   localparam logic [2:0] SEQ_RD_NXT = 3'd6;

   localparam logic REG_QUARTER_DELAY = 1'b0;
   localparam logic REG_STRETCH_LIMIT = 1'b1;

   localparam logic [15:0] QUARTER_DELAY_RESET = 16'd40;
   localparam logic [15:0] STRETCH_LIMIT_RESET = 16'd6000;

   localparam int TBL_LEN = 12;

   localparam micro_type T_START [TBL_LEN] = '{MO_SDA_REL, MO_Q, MO_WAIT, MO_Q, MO_SDA_LOW,
      MO_Q, MO_Q, MO_SCL_LOW, MO_Q, MO_END, MO_END, MO_END};
   localparam micro_type T_RESTART [TBL_LEN] = '{MO_SDA_REL, MO_Q, MO_WAIT, MO_Q, MO_Q,
      MO_SDA_LOW, MO_Q, MO_Q, MO_SCL_LOW, MO_Q, MO_END, MO_END};
   localparam micro_type T_STOP [TBL_LEN] = '{MO_SDA_LOW, MO_Q, MO_WAIT, MO_Q, MO_Q,
      MO_SDA_REL, MO_Q, MO_Q, MO_END, MO_END, MO_END, MO_END};
   localparam micro_type T_PUT [TBL_LEN] = '{MO_SDA_BIT, MO_Q, MO_WAIT, MO_Q, MO_Q,
      MO_SCL_LOW, MO_Q, MO_END, MO_END, MO_END, MO_END, MO_END};
   localparam micro_type T_GET [TBL_LEN] = '{MO_SDA_REL, MO_Q, MO_WAIT, MO_Q, MO_SAMPLE,
      MO_Q, MO_SCL_LOW, MO_Q, MO_END, MO_END, MO_END, MO_END};
   localparam micro_type T_PULSE [TBL_LEN] = '{MO_SCL_REL, MO_Q, MO_Q, MO_SCL_LOW, MO_Q,
      MO_Q, MO_END, MO_END, MO_END, MO_END, MO_END, MO_END};
   localparam micro_type T_TAIL [TBL_LEN] = '{MO_SCL_REL, MO_Q, MO_END, MO_END, MO_END,
      MO_END, MO_END, MO_END, MO_END, MO_END, MO_END, MO_END};

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  mpc;
      logic [2:0]  seq;
      logic [15:0] quarter_count;
      logic [15:0] stretch_count;
      logic [3:0]  bit_index;
      logic [7:0]  shift_byte;
      logic [7:0]  byte_index;
      logic [7:0]  block_count;
      logic [15:0] word_hold;
      logic [2:0]  lat_op;
      logic [6:0]  lat_addr;
      logic [7:0]  lat_cmd;
      logic [15:0] lat_data;
      logic [7:0]  lat_max;
      logic [1:0]  result_status;
      logic        truncated_flag;
      logic        nack_flag;
      logic        ack_bit;
      logic        drv_scl;
      logic        drv_sda;
   } state_type;

   typedef struct packed {
      logic        scl_in;
      logic        sda_in;
      logic        start_req;
      logic [2:0]  op;
      logic [6:0]  addr;
      logic [7:0]  command;
      logic [15:0] write_data;
      logic [7:0]  max_len;
   } request_type;

   typedef struct packed {
      logic        scl_low;
      logic        sda_low;
      logic        busy_res;
      logic        done_res;
      logic [1:0]  status;
      logic [15:0] read_word;
      logic [7:0]  read_count;
      logic        byte_valid;
      logic [7:0]  byte_data;
      logic        byte_last;
   } result_type;

   function automatic micro_type micro_at(phase_type ph, logic [3:0] bi, logic [3:0] pc);
      micro_type m;
      m = MO_END;
      if (pc < 4'(TBL_LEN)) begin
         unique case (ph)
            PH_START:   m = T_START[pc];
            PH_RESTART: m = T_RESTART[pc];
            PH_STOP:    m = T_STOP[pc];
            PH_WBYTE:   m = (bi < 4'd8) ? T_PUT[pc] : T_GET[pc];
            PH_RBYTE:   m = (bi < 4'd8) ? T_GET[pc] : T_PUT[pc];
            PH_PULSE:   m = T_PULSE[pc];
            default:    m = T_TAIL[pc];
         endcase
      end
      return m;
   endfunction

endpackage

// ===== rtl/smbus_master_transaction_engine_core.sv =====
// top level of the smbus master transaction engine: state, config and result registers
// depends on smte_pkg, smte_step and smbus_master_transaction_engine_core_defines.svh
//
// Each request is one clock tick of the bus engine: sampled scl and sda levels plus an
// optional transaction start. One result comes back per request, holding the line
// drives, busy and done flags, status, read data and any received byte. A request is
// taken every cycle and its result appears in the result register on the next cycle;
// the only thing that slows the flow is the result side holding off ready. All bus
// timing is counted in requests, quarter_delay requests per quarter bit.
`include "smbus_master_transaction_engine_core_defines.svh"
module smbus_master_transaction_engine_core #(
   parameter int RECOVER_PULSES = 9
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_scl_in,
   input  logic        req_sda_in,
   input  logic        req_start_req,
   input  logic [2:0]  req_op,
   input  logic [6:0]  req_addr,
   input  logic [7:0]  req_command,
   input  logic [15:0] req_write_data,
   input  logic [7:0]  req_max_len,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl_low,
   output logic        rsp_sda_low,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_read_word,
   output logic [7:0]  rsp_read_count,
   output logic        rsp_byte_valid,
   output logic [7:0]  rsp_byte_data,
   output logic        rsp_byte_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   smte_pkg::state_type   state_ff, state_in;
   smte_pkg::result_type  result_ff, result_in;
   smte_pkg::request_type req;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           quarter_delay_ff, quarter_delay_in;
   logic [15:0]           stretch_limit_ff, stretch_limit_in;
   logic                  accept;

   assign req = '{scl_in: req_scl_in, sda_in: req_sda_in, start_req: req_start_req,
                  op: req_op, addr: req_addr, command: req_command,
                  write_data: req_write_data, max_len: req_max_len};

   smte_step #(
      .RECOVER_PULSES(RECOVER_PULSES)
   ) u_step (
      .cur          (state_ff),
      .req          (req),
      .quarter_delay(quarter_delay_ff),
      .stretch_limit(stretch_limit_ff),
      .nxt          (state_in),
      .res          (result_in)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      rsp_valid_in = accept ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      quarter_delay_in = quarter_delay_ff;
      stretch_limit_in = stretch_limit_ff;
      if (csr_valid) begin
         unique case (csr_index)
            smte_pkg::REG_QUARTER_DELAY: quarter_delay_in = csr_wdata;
            default:                     stretch_limit_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         rsp_valid_ff <= 1'b0;
         quarter_delay_ff <= smte_pkg::QUARTER_DELAY_RESET;
         stretch_limit_ff <= smte_pkg::STRETCH_LIMIT_RESET;
      end else begin
         if (accept) state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         quarter_delay_ff <= quarter_delay_in;
         stretch_limit_ff <= stretch_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) result_ff <= result_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scl_low    = result_ff.scl_low;
   assign rsp_sda_low    = result_ff.sda_low;
   assign rsp_busy_res   = result_ff.busy_res;
   assign rsp_done_res   = result_ff.done_res;
   assign rsp_status     = result_ff.status;
   assign rsp_read_word  = result_ff.read_word;
   assign rsp_read_count = result_ff.read_count;
   assign rsp_byte_valid = result_ff.byte_valid;
   assign rsp_byte_data  = result_ff.byte_data;
   assign rsp_byte_last  = result_ff.byte_last;

   `SMTE_ASSERT(a_accept_gives_result, clock, reset, req_valid && req_ready |=> rsp_valid)
   `SMTE_ASSERT_IMP(a_done_not_busy, clock, reset, rsp_valid && rsp_done_res, !rsp_busy_res)
   `SMTE_ASSERT_IMP(a_word_only_on_done, clock, reset, rsp_valid && rsp_read_word != 16'd0, rsp_done_res)
   `SMTE_ASSERT_IMP(a_byte_fields_idle, clock, reset, rsp_valid && !rsp_byte_valid, rsp_byte_data == 8'd0 && !rsp_byte_last)

endmodule

// ===== rtl/smte_step.sv =====
// next-state logic of one clock tick of the smbus master transaction engine
// depends on smte_pkg
module smte_step #(
   parameter int RECOVER_PULSES = 9
) (
   input  smte_pkg::state_type   cur,
   input  smte_pkg::request_type req,
   input  logic [15:0]           quarter_delay,
   input  logic [15:0]           stretch_limit,
   output smte_pkg::state_type   nxt,
   output smte_pkg::result_type  res
);

   function automatic smte_pkg::state_type enter(smte_pkg::state_type st,
                                                 smte_pkg::phase_type ph);
      smte_pkg::state_type o;
      o = st;
      o.phase = ph;
      o.mpc = 4'd0;
      o.bit_index = 4'd0;
      o.quarter_count = 16'd0;
      o.stretch_count = 16'd0;
      return o;
   endfunction

   function automatic smte_pkg::result_type finish(smte_pkg::state_type st,
                                                   smte_pkg::result_type ri);
      smte_pkg::result_type o;
      logic [1:0] code;
      o = ri;
      code = st.result_status;
      if (code == smte_pkg::ST_OK && st.truncated_flag) code = smte_pkg::ST_TRUNC;
      o.done_res = 1'b1;
      o.status = code;
      o.read_word = (code == smte_pkg::ST_OK && (st.lat_op == smte_pkg::OP_RD_BYTE ||
                     st.lat_op == smte_pkg::OP_RD_WORD)) ? st.word_hold : 16'd0;
      o.read_count = (st.lat_op == smte_pkg::OP_RD_BLOCK && (code == smte_pkg::ST_OK ||
                      code == smte_pkg::ST_TRUNC)) ? st.block_count : 8'd0;
      return o;
   endfunction

   smte_pkg::state_type  s;
   smte_pkg::result_type r;
   smte_pkg::micro_type  mo;
   logic                 halt;
   logic                 elem;
   logic [4:0]           bi_inc;
   logic [7:0]           b;
   logic [7:0]           n;
   logic [7:0]           bidx;
   logic                 last;
   logic                 bit_val;
   logic [15:0]          qd;
   logic [15:0]          sl;
   logic [15:0]          qtmp;
   logic [15:0]          stmp;

   always_comb begin
      s = cur;
      r = '0;
      halt = 1'b0;
      elem = 1'b0;
      bi_inc = '0;
      b = '0;
      n = '0;
      bidx = '0;
      last = 1'b0;
      bit_val = 1'b0;
      qtmp = '0;
      stmp = '0;
      mo = smte_pkg::MO_END;
      qd = (quarter_delay == 16'd0) ? 16'd1 : quarter_delay;
      sl = (stretch_limit == 16'd0) ? 16'd1 : stretch_limit;

      if (s.phase == smte_pkg::PH_IDLE && req.start_req && req.op <= smte_pkg::OP_RECOVER) begin
         s.lat_op = req.op;
         s.lat_addr = req.addr;
         s.lat_cmd = req.command;
         s.lat_data = req.write_data;
         s.lat_max = req.max_len;
         s.result_status = smte_pkg::ST_OK;
         s.truncated_flag = 1'b0;
         s.word_hold = '0;
         s.block_count = '0;
         s.byte_index = '0;
         s.seq = '0;
         s.ack_bit = 1'b0;
         s.nack_flag = 1'b0;
         if (req.op == smte_pkg::OP_RECOVER) begin
            s.drv_sda = 1'b0;
            s = enter(s, smte_pkg::PH_PULSE);
         end else begin
            s = enter(s, smte_pkg::PH_START);
         end
      end

      // zero-time micro-ops up to the next wait
      for (int i = 0; i < 4; i++) begin
         if (!halt && s.phase != smte_pkg::PH_IDLE) begin
            mo = smte_pkg::micro_at(s.phase, s.bit_index, s.mpc);
            elem = 1'b0;
            unique case (mo)
               smte_pkg::MO_Q, smte_pkg::MO_WAIT: halt = 1'b1;
               smte_pkg::MO_SDA_REL: begin
                  s.drv_sda = 1'b0;
                  s.mpc = s.mpc + 4'd1;
               end
               smte_pkg::MO_SDA_LOW: begin
                  s.drv_sda = 1'b1;
                  s.mpc = s.mpc + 4'd1;
               end
               smte_pkg::MO_SDA_BIT: begin
                  if (s.phase == smte_pkg::PH_WBYTE && s.bit_index < 4'd8)
                     bit_val = s.shift_byte[3'd7 - s.bit_index[2:0]];
                  else
                     bit_val = s.nack_flag;
                  s.drv_sda = !bit_val;
                  s.mpc = s.mpc + 4'd1;
               end
               smte_pkg::MO_SCL_LOW: begin
                  s.drv_scl = 1'b1;
                  s.mpc = s.mpc + 4'd1;
               end
               smte_pkg::MO_SCL_REL: begin
                  s.drv_scl = 1'b0;
                  s.mpc = s.mpc + 4'd1;
               end
               smte_pkg::MO_SAMPLE: begin
                  if (s.phase == smte_pkg::PH_WBYTE) s.ack_bit = req.sda_in;
                  else s.shift_byte = {s.shift_byte[6:0], req.sda_in};
                  s.mpc = s.mpc + 4'd1;
               end
               default: begin
                  bi_inc = {1'b0, s.bit_index} + 5'd1;
                  if (s.phase == smte_pkg::PH_WBYTE || s.phase == smte_pkg::PH_RBYTE) begin
                     if (bi_inc < 5'd9) begin
                        s.bit_index = bi_inc[3:0];
                        s.mpc = 4'd0;
                     end else begin
                        elem = 1'b1;
                     end
                  end else if (s.phase == smte_pkg::PH_PULSE) begin
                     if (bi_inc < 5'(RECOVER_PULSES)) begin
                        s.bit_index = bi_inc[3:0];
                        s.mpc = 4'd0;
                     end else begin
                        s = enter(s, smte_pkg::PH_TAIL);
                     end
                  end else if (s.phase == smte_pkg::PH_STOP) begin
                     r = finish(s, r);
                     s = enter(s, smte_pkg::PH_IDLE);
                     halt = 1'b1;
                  end else begin
                     elem = 1'b1;
                  end
               end
            endcase

            if (elem) begin
               b = s.shift_byte;
               unique case (s.phase)
                  smte_pkg::PH_START: begin
                     s.shift_byte = {s.lat_addr, 1'b0};
                     s.seq = smte_pkg::SEQ_ADDR;
                     s = enter(s, smte_pkg::PH_WBYTE);
                  end
                  smte_pkg::PH_RESTART: begin
                     s.shift_byte = {s.lat_addr, 1'b1};
                     s.seq = smte_pkg::SEQ_DATA_H;
                     s = enter(s, smte_pkg::PH_WBYTE);
                  end
                  smte_pkg::PH_WBYTE: begin
                     if (s.ack_bit) begin
                        s.result_status = smte_pkg::ST_NAK;
                        s = enter(s, smte_pkg::PH_STOP);
                     end else if (s.seq == smte_pkg::SEQ_ADDR) begin
                        if (s.lat_op == smte_pkg::OP_PING) begin
                           s = enter(s, smte_pkg::PH_STOP);
                        end else begin
                           s.shift_byte = s.lat_cmd;
                           s.seq = smte_pkg::SEQ_CMD;
                           s = enter(s, smte_pkg::PH_WBYTE);
                        end
                     end else if (s.seq == smte_pkg::SEQ_CMD) begin
                        if (s.lat_op == smte_pkg::OP_WR_BYTE ||
                            s.lat_op == smte_pkg::OP_WR_WORD) begin
                           s.shift_byte = s.lat_data[7:0];
                           s.seq = smte_pkg::SEQ_DATA_L;
                           s = enter(s, smte_pkg::PH_WBYTE);
                        end else begin
                           s = enter(s, smte_pkg::PH_RESTART);
                        end
                     end else if (s.seq == smte_pkg::SEQ_DATA_L) begin
                        if (s.lat_op == smte_pkg::OP_WR_WORD) begin
                           s.shift_byte = s.lat_data[15:8];
                           s.seq = smte_pkg::SEQ_DATA_H;
                           s = enter(s, smte_pkg::PH_WBYTE);
                        end else begin
                           s = enter(s, smte_pkg::PH_STOP);
                        end
                     end else if (s.seq == smte_pkg::SEQ_DATA_H &&
                                  s.lat_op >= smte_pkg::OP_RD_BYTE &&
                                  s.lat_op <= smte_pkg::OP_RD_BLOCK) begin
                        s.shift_byte = '0;
                        s.nack_flag = (s.lat_op == smte_pkg::OP_RD_BYTE);
                        s.seq = smte_pkg::SEQ_RD_1ST;
                        s = enter(s, smte_pkg::PH_RBYTE);
                     end else begin
                        s = enter(s, smte_pkg::PH_STOP);
                     end
                  end
                  smte_pkg::PH_RBYTE: begin
                     if (s.seq == smte_pkg::SEQ_RD_1ST) begin
                        if (s.lat_op == smte_pkg::OP_RD_BYTE) begin
                           s.word_hold = {8'd0, b};
                           r.byte_valid = 1'b1;
                           r.byte_data = b;
                           r.byte_last = 1'b1;
                           s = enter(s, smte_pkg::PH_STOP);
                        end else if (s.lat_op == smte_pkg::OP_RD_WORD) begin
                           s.word_hold = {8'd0, b};
                           r.byte_valid = 1'b1;
                           r.byte_data = b;
                           s.shift_byte = '0;
                           s.nack_flag = 1'b1;
                           s.seq = smte_pkg::SEQ_RD_NXT;
                           s = enter(s, smte_pkg::PH_RBYTE);
                        end else begin
                           n = b;
                           if (b > s.lat_max) begin
                              s.truncated_flag = 1'b1;
                              n = s.lat_max;
                           end
                           s.block_count = n;
                           s.byte_index = '0;
                           if (n == 8'd0) begin
                              s = enter(s, smte_pkg::PH_STOP);
                           end else begin
                              s.shift_byte = '0;
                              s.nack_flag = (n == 8'd1);
                              s.seq = smte_pkg::SEQ_RD_NXT;
                              s = enter(s, smte_pkg::PH_RBYTE);
                           end
                        end
                     end else if (s.lat_op == smte_pkg::OP_RD_WORD) begin
                        s.word_hold = {b, s.word_hold[7:0]};
                        r.byte_valid = 1'b1;
                        r.byte_data = b;
                        r.byte_last = 1'b1;
                        s = enter(s, smte_pkg::PH_STOP);
                     end else begin
                        last = ({1'b0, s.byte_index} + 9'd1) >= {1'b0, s.block_count};
                        r.byte_valid = 1'b1;
                        r.byte_data = b;
                        r.byte_last = last;
                        bidx = s.byte_index + 8'd1;
                        s.byte_index = bidx;
                        if (last) begin
                           s = enter(s, smte_pkg::PH_STOP);
                        end else begin
                           s.shift_byte = '0;
                           s.nack_flag = ({1'b0, bidx} + 9'd1) >= {1'b0, s.block_count};
                           s.seq = smte_pkg::SEQ_RD_NXT;
                           s = enter(s, smte_pkg::PH_RBYTE);
                        end
                     end
                  end
                  default: s = enter(s, smte_pkg::PH_STOP);
               endcase
            end
         end
      end

      // the wait that ends this tick
      if (s.phase != smte_pkg::PH_IDLE) begin
         mo = smte_pkg::micro_at(s.phase, s.bit_index, s.mpc);
         if (mo == smte_pkg::MO_Q) begin
            qtmp = ((s.quarter_count == 16'd0) ? qd : s.quarter_count) - 16'd1;
            s.quarter_count = qtmp;
            if (qtmp == 16'd0) s.mpc = s.mpc + 4'd1;
         end else if (mo == smte_pkg::MO_WAIT) begin
            if (s.stretch_count == 16'd0) begin
               s.drv_scl = 1'b0;
               s.stretch_count = sl;
            end else if (s.quarter_count != 16'd0) begin
               s.quarter_count = s.quarter_count - 16'd1;
            end else if (req.scl_in) begin
               s.stretch_count = '0;
               s.mpc = s.mpc + 4'd1;
            end else begin
               stmp = s.stretch_count - 16'd1;
               s.stretch_count = stmp;
               if (stmp == 16'd0) begin
                  if (s.phase == smte_pkg::PH_STOP) begin
                     r = finish(s, r);
                     s = enter(s, smte_pkg::PH_IDLE);
                  end else begin
                     s.result_status = smte_pkg::ST_TIMEOUT;
                     s = enter(s, smte_pkg::PH_STOP);
                  end
               end else begin
                  s.quarter_count = qd;
               end
            end
         end
      end

      r.scl_low = s.drv_scl;
      r.sda_low = s.drv_sda;
      r.busy_res = (s.phase != smte_pkg::PH_IDLE);
      nxt = s;
      res = r;
   end

endmodule

// ===== dv/smbus_master_transaction_engine_core_test.sv =====
// testbench for smbus_master_transaction_engine_core: per-tick bus model, config writes, checks
// depends on smte_pkg and the smbus_master_transaction_engine_core rtl
module smbus_master_transaction_engine_core_test;

   localparam int PULSES = 9;
   localparam logic [2:0] OP_UNUSED = 3'd7;

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic        req_scl_in, req_sda_in, req_start_req;
   logic [2:0]  req_op;
   logic [6:0]  req_addr;
   logic [7:0]  req_command;
   logic [15:0] req_write_data;
   logic [7:0]  req_max_len;
   logic        rsp_valid, rsp_ready;
   logic        rsp_scl_low, rsp_sda_low, rsp_busy_res, rsp_done_res;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_read_word;
   logic [7:0]  rsp_read_count;
   logic        rsp_byte_valid;
   logic [7:0]  rsp_byte_data;
   logic        rsp_byte_last;
   logic        csr_valid, csr_ready, csr_index;
   logic [15:0] csr_wdata;

   smbus_master_transaction_engine_core #(.RECOVER_PULSES(PULSES)) u_top (.*);

   // bus engine model state
   logic [15:0]         m_qdelay, m_slimit;
   smte_pkg::phase_type m_phase;
   int                  m_mpc;
   logic [2:0]          m_seq;
   logic [15:0]         m_qcount, m_scount;
   logic [3:0]          m_bit;
   logic [7:0]          m_shift, m_bidx, m_bcount;
   logic [15:0]         m_word;
   logic [2:0]          m_op;
   logic [6:0]          m_addr;
   logic [7:0]          m_cmd, m_max;
   logic [15:0]         m_data;
   logic [1:0]          m_status;
   logic                m_trunc, m_nack, m_ack, m_scl, m_sda;
   smte_pkg::result_type m_out;

   smte_pkg::result_type expected_ticks[$];
   int          fail_count, tick_count, done_count, byte_count;
   int          tx_idle_pct, rx_stall_pct;

   function automatic logic [15:0] quarter_ticks();
      return (m_qdelay == 0) ? 16'd1 : m_qdelay;
   endfunction

   function automatic void enter_phase(smte_pkg::phase_type ph);
      m_phase = ph; m_mpc = 0; m_bit = 0; m_qcount = 0; m_scount = 0;
   endfunction

   function automatic void load_write(logic [7:0] b, logic [2:0] s);
      m_shift = b; m_seq = s; enter_phase(smte_pkg::PH_WBYTE);
   endfunction

   function automatic void load_read(logic nack, logic [2:0] s);
      m_shift = 0; m_nack = nack; m_seq = s; enter_phase(smte_pkg::PH_RBYTE);
   endfunction

   function automatic void abort_with(logic [1:0] code);
      m_status = code; enter_phase(smte_pkg::PH_STOP);
   endfunction

   function automatic void show_byte(logic [7:0] b, logic last);
      m_out.byte_valid = 1; m_out.byte_data = b; m_out.byte_last = last;
   endfunction

   function automatic void close_transaction();
      logic [1:0] st;
      st = m_status;
      if (st == smte_pkg::ST_OK && m_trunc) st = smte_pkg::ST_TRUNC;
      m_out.done_res = 1;
      m_out.status = st;
      m_out.read_word = (st == smte_pkg::ST_OK && (m_op == smte_pkg::OP_RD_BYTE ||
                         m_op == smte_pkg::OP_RD_WORD)) ? m_word : 0;
      m_out.read_count = (m_op == smte_pkg::OP_RD_BLOCK && (st == smte_pkg::ST_OK ||
                          st == smte_pkg::ST_TRUNC)) ? m_bcount : 0;
      enter_phase(smte_pkg::PH_IDLE);
   endfunction

   function automatic void element_done();
      logic [7:0] b, n;
      logic last;
      b = m_shift;
      case (m_phase)
         smte_pkg::PH_START:   load_write({m_addr, 1'b0}, smte_pkg::SEQ_ADDR);
         smte_pkg::PH_RESTART: load_write({m_addr, 1'b1}, smte_pkg::SEQ_DATA_H);
         smte_pkg::PH_WBYTE: begin
            if (m_ack) abort_with(smte_pkg::ST_NAK);
            else if (m_seq == smte_pkg::SEQ_ADDR) begin
               if (m_op == smte_pkg::OP_PING) enter_phase(smte_pkg::PH_STOP);
               else load_write(m_cmd, smte_pkg::SEQ_CMD);
            end else if (m_seq == smte_pkg::SEQ_CMD) begin
               if (m_op == smte_pkg::OP_WR_BYTE || m_op == smte_pkg::OP_WR_WORD)
                  load_write(m_data[7:0], smte_pkg::SEQ_DATA_L);
               else enter_phase(smte_pkg::PH_RESTART);
            end else if (m_seq == smte_pkg::SEQ_DATA_L) begin
               if (m_op == smte_pkg::OP_WR_WORD) load_write(m_data[15:8], smte_pkg::SEQ_DATA_H);
               else enter_phase(smte_pkg::PH_STOP);
            end else if (m_seq == smte_pkg::SEQ_DATA_H && m_op >= smte_pkg::OP_RD_BYTE &&
                         m_op <= smte_pkg::OP_RD_BLOCK)
               load_read(m_op == smte_pkg::OP_RD_BYTE, smte_pkg::SEQ_RD_1ST);
            else enter_phase(smte_pkg::PH_STOP);
         end
         smte_pkg::PH_RBYTE: begin
            if (m_seq == smte_pkg::SEQ_RD_1ST) begin
               if (m_op == smte_pkg::OP_RD_BYTE) begin
                  m_word = {8'd0, b}; show_byte(b, 1); enter_phase(smte_pkg::PH_STOP);
               end else if (m_op == smte_pkg::OP_RD_WORD) begin
                  m_word = {8'd0, b}; show_byte(b, 0); load_read(1, smte_pkg::SEQ_RD_NXT);
               end else begin
                  n = b;
                  if (n > m_max) begin
                     m_trunc = 1; n = m_max;
                  end
                  m_bcount = n; m_bidx = 0;
                  if (n == 0) enter_phase(smte_pkg::PH_STOP);
                  else load_read(n == 1, smte_pkg::SEQ_RD_NXT);
               end
            end else if (m_op == smte_pkg::OP_RD_WORD) begin
               m_word[15:8] = b; show_byte(b, 1); enter_phase(smte_pkg::PH_STOP);
            end else begin
               last = (int'(m_bidx) + 1 >= int'(m_bcount));
               show_byte(b, last);
               m_bidx = m_bidx + 1;
               if (last) enter_phase(smte_pkg::PH_STOP);
               else load_read(int'(m_bidx) + 1 >= int'(m_bcount), smte_pkg::SEQ_RD_NXT);
            end
         end
         default: enter_phase(smte_pkg::PH_STOP);
      endcase
   endfunction

   function automatic smte_pkg::micro_type micro_now();
      if (m_mpc >= smte_pkg::TBL_LEN) return smte_pkg::MO_END;
      case (m_phase)
         smte_pkg::PH_START:   return smte_pkg::T_START[m_mpc];
         smte_pkg::PH_RESTART: return smte_pkg::T_RESTART[m_mpc];
         smte_pkg::PH_STOP:    return smte_pkg::T_STOP[m_mpc];
         smte_pkg::PH_WBYTE:
            return (m_bit < 8) ? smte_pkg::T_PUT[m_mpc] : smte_pkg::T_GET[m_mpc];
         smte_pkg::PH_RBYTE:
            return (m_bit < 8) ? smte_pkg::T_GET[m_mpc] : smte_pkg::T_PUT[m_mpc];
         smte_pkg::PH_PULSE:   return smte_pkg::T_PULSE[m_mpc];
         default:              return smte_pkg::T_TAIL[m_mpc];
      endcase
   endfunction

   function automatic void advance_engine(logic scl, logic sda);
      int guard;
      logic stop, b;
      smte_pkg::micro_type m;
      stop = 0;
      for (guard = 0; guard < 16 && m_phase != smte_pkg::PH_IDLE && !stop; guard++) begin
         m = micro_now();
         case (m)
            smte_pkg::MO_END: begin
               if (m_phase == smte_pkg::PH_WBYTE || m_phase == smte_pkg::PH_RBYTE) begin
                  m_bit++;
                  if (m_bit < 9) m_mpc = 0;
                  else element_done();
               end else if (m_phase == smte_pkg::PH_PULSE) begin
                  m_bit++;
                  if (m_bit < PULSES) m_mpc = 0;
                  else enter_phase(smte_pkg::PH_TAIL);
               end else if (m_phase == smte_pkg::PH_STOP) begin
                  close_transaction(); stop = 1;
               end else element_done();
            end
            smte_pkg::MO_Q: begin
               if (m_qcount == 0) m_qcount = quarter_ticks();
               m_qcount--;
               if (m_qcount == 0) m_mpc++;
               stop = 1;
            end
            smte_pkg::MO_WAIT: begin
               stop = 1;
               if (m_scount == 0) begin
                  m_scl = 0;
                  m_scount = (m_slimit == 0) ? 16'd1 : m_slimit;
               end else if (m_qcount > 0) m_qcount--;
               else if (scl) begin
                  m_scount = 0; m_mpc++;
               end else begin
                  m_scount--;
                  if (m_scount == 0) begin
                     if (m_phase == smte_pkg::PH_STOP) close_transaction();
                     else abort_with(smte_pkg::ST_TIMEOUT);
                  end else m_qcount = quarter_ticks();
               end
            end
            smte_pkg::MO_SDA_REL: begin m_sda = 0; m_mpc++; end
            smte_pkg::MO_SDA_LOW: begin m_sda = 1; m_mpc++; end
            smte_pkg::MO_SDA_BIT: begin
               if (m_phase == smte_pkg::PH_WBYTE && m_bit < 8) b = m_shift[7 - m_bit];
               else b = m_nack;
               m_sda = !b; m_mpc++;
            end
            smte_pkg::MO_SCL_LOW: begin m_scl = 1; m_mpc++; end
            smte_pkg::MO_SCL_REL: begin m_scl = 0; m_mpc++; end
            default: begin
               if (m_phase == smte_pkg::PH_WBYTE) m_ack = sda;
               else m_shift = {m_shift[6:0], sda};
               m_mpc++;
            end
         endcase
      end
   endfunction

   function automatic smte_pkg::result_type model_bus_tick(smte_pkg::request_type r);
      m_out = '0;
      if (m_phase == smte_pkg::PH_IDLE && r.start_req && r.op <= smte_pkg::OP_RECOVER) begin
         m_op = r.op; m_addr = r.addr; m_cmd = r.command; m_data = r.write_data;
         m_max = r.max_len;
         m_status = smte_pkg::ST_OK; m_trunc = 0; m_word = 0; m_bcount = 0; m_bidx = 0;
         m_seq = 0; m_ack = 0; m_nack = 0;
         if (r.op == smte_pkg::OP_RECOVER) begin
            m_sda = 0; enter_phase(smte_pkg::PH_PULSE);
         end else enter_phase(smte_pkg::PH_START);
      end
      advance_engine(r.scl_in, r.sda_in);
      m_out.scl_low = m_scl;
      m_out.sda_low = m_sda;
      m_out.busy_res = (m_phase != smte_pkg::PH_IDLE);
      return m_out;
   endfunction

   function automatic void model_reset();
      m_qdelay = smte_pkg::QUARTER_DELAY_RESET; m_slimit = smte_pkg::STRETCH_LIMIT_RESET;
      enter_phase(smte_pkg::PH_IDLE);
      m_seq = 0; m_shift = 0; m_bidx = 0; m_bcount = 0; m_word = 0;
      m_op = 0; m_addr = 0; m_cmd = 0; m_data = 0; m_max = 0;
      m_status = smte_pkg::ST_OK; m_trunc = 0; m_nack = 0; m_ack = 0; m_scl = 0; m_sda = 0;
   endfunction

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(negedge clock) rsp_ready = ($urandom_range(99) >= rx_stall_pct);

   task automatic report(string field, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $display("%0t mismatch %s expected %0h actual %0h", $time, field, exp_v, act_v);
         fail_count++;
      end
   endtask

   // compare every accepted result with the oldest prediction
   always @(posedge clock) begin
      smte_pkg::result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_ticks.size() == 0) begin
            $display("%0t unexpected result, nothing predicted", $time);
            fail_count++;
         end else begin
            e = expected_ticks.pop_front();
            report("scl_low", e.scl_low, rsp_scl_low);
            report("sda_low", e.sda_low, rsp_sda_low);
            report("busy_res", e.busy_res, rsp_busy_res);
            report("done_res", e.done_res, rsp_done_res);
            report("status", e.status, rsp_status);
            report("read_word", e.read_word, rsp_read_word);
            report("read_count", e.read_count, rsp_read_count);
            report("byte_valid", e.byte_valid, rsp_byte_valid);
            report("byte_data", e.byte_data, rsp_byte_data);
            report("byte_last", e.byte_last, rsp_byte_last);
         end
      end
   end

   task automatic send_tick(smte_pkg::request_type r);
      smte_pkg::result_type e;
      while ($urandom_range(99) < tx_idle_pct) begin
         @(negedge clock);
         req_valid = 0;
      end
      @(negedge clock);
      req_valid = 1;
      {req_scl_in, req_sda_in, req_start_req, req_op, req_addr, req_command,
       req_write_data, req_max_len} = r;
      do @(posedge clock); while (!req_ready);
      e = model_bus_tick(r);
      tick_count++;
      if (e.done_res) done_count++;
      if (e.byte_valid) byte_count++;
      expected_ticks.push_back(e);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 0;
      wait (expected_ticks.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] value);
      drain();
      @(negedge clock);
      csr_valid = 1; csr_index = idx; csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      if (idx == smte_pkg::REG_QUARTER_DELAY) m_qdelay = value;
      else m_slimit = value;
      @(negedge clock);
      csr_valid = 0;
   endtask

   // slave side: mostly acks, some clock stretching, random read data
   function automatic smte_pkg::request_type bus_item(logic allow_start);
      smte_pkg::request_type r;
      r.scl_in = m_scl ? 1'b0 : ($urandom_range(9) != 0);
      if (m_phase == smte_pkg::PH_WBYTE && m_bit == 8) r.sda_in = ($urandom_range(99) < 12);
      else r.sda_in = $urandom_range(1);
      r.start_req = allow_start && ((m_phase == smte_pkg::PH_IDLE) ? $urandom_range(1) :
                                    ($urandom_range(9) == 0));
      r.op = $urandom_range(7);
      r.addr = $urandom_range(127);
      r.command = $urandom_range(255);
      r.write_data = $urandom_range(65535);
      r.max_len = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
      return r;
   endfunction

   task automatic test_directed();
      smte_pkg::request_type r;
      int i;
      r = '0;
      send_tick(r);
      r.start_req = 1; r.op = OP_UNUSED;
      send_tick(r);
      r.op = smte_pkg::OP_PING; r.addr = 7'h7f; r.command = 8'hff; r.write_data = 16'hffff;
      r.max_len = 8'hff; r.scl_in = 1; r.sda_in = 1;
      send_tick(r);
      r.op = smte_pkg::OP_RD_BLOCK;
      for (i = 0; i < 8; i++) send_tick(r);
      r.start_req = 0; r.scl_in = 0; r.sda_in = 0;
      for (i = 0; i < 8; i++) send_tick(r);
   endtask

   task automatic test_slow_quarter();
      int i;
      write_csr(smte_pkg::REG_QUARTER_DELAY, 16'hffff);
      write_csr(smte_pkg::REG_STRETCH_LIMIT, 16'd6000);
      for (i = 0; i < 6; i++) send_tick(bus_item(1'b0));
   endtask

   task automatic test_traffic(int tx_pct, int rx_pct, logic [15:0] qd, logic [15:0] sl,
                               int n, logic hold_off);
      int i;
      write_csr(smte_pkg::REG_QUARTER_DELAY, qd);
      write_csr(smte_pkg::REG_STRETCH_LIMIT, sl);
      tx_idle_pct = tx_pct; rx_stall_pct = rx_pct;
      for (i = 0; i < n; i++) begin
         if (hold_off && i % 25 == 0) begin
            @(negedge clock);
            req_valid = 0;
            wait (expected_ticks.size() == 0);
         end
         send_tick(bus_item(1'b1));
      end
      tx_idle_pct = 0; rx_stall_pct = 0;
   endtask

   initial begin
      int waited;
      fail_count = 0; tick_count = 0; done_count = 0; byte_count = 0;
      tx_idle_pct = 0; rx_stall_pct = 0;
      reset = 1; req_valid = 0; req_scl_in = 0; req_sda_in = 0; req_start_req = 0;
      req_op = 0; req_addr = 0; req_command = 0; req_write_data = 0; req_max_len = 0;
      csr_valid = 0; csr_index = 0; csr_wdata = 0; rsp_ready = 0;
      model_reset();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_directed();
      test_slow_quarter();
      test_traffic(0, 0, 16'd1, 16'd5, 110, 1'b0);
      test_traffic(73, 0, 16'd2, 16'hffff, 100, 1'b0);
      test_traffic(0, 73, 16'd0, 16'd1, 100, 1'b0);
      test_traffic(19, 19, 16'd1, 16'd0, 100, 1'b0);
      test_traffic(0, 0, 16'd3, 16'd20, 60, 1'b1);
      @(negedge clock);
      req_valid = 0;
      waited = 0;
      while (expected_ticks.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      $display("ran %0d bus ticks over six timing settings and four idling mixes", tick_count);
      $display("%0d transactions ended, %0d read bytes streamed", done_count, byte_count);
      if (fail_count == 0 && expected_ticks.size() == 0)
         $display("smbus_master_transaction_engine_core test passed");
      else
         $display("smbus_master_transaction_engine_core test failed");
      $finish;
   end

   initial begin
      #20000000;
      $display("smbus_master_transaction_engine_core test failed");
      $finish;
   end

endmodule
